// ===== sv/ltmd_pkg.sv =====
// Shared types, field widths and codes for the lockstep triple mismatch detector.
package ltmd_pkg;

	localparam int HISTORY_DEPTH = 256;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

	localparam int TICK_W   = 64;
	localparam int WORD_W   = 32;
	localparam int LEVEL_W  = 8;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX    = '1;
	localparam logic [LEVEL_W-1:0] THRESH_RESET = LEVEL_W'(8);

	// stream payload layout
	localparam int S_FIELDS_W = TICK_W + 3 * WORD_W + 2;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;
	localparam int M_FIELDS_W = 2 + TICK_W + LEVEL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// register port
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int REG_IDX_W  = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);

	typedef enum logic [CMD_W-1:0] {
		CMD_SUBMIT = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED  = 2'd0,
		ST_STORED   = 2'd1,
		ST_MATCH    = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic        [TICK_W-1:0] tick;
		logic signed [WORD_W-1:0] word_c;
		logic signed [WORD_W-1:0] word_b;
		logic signed [WORD_W-1:0] word_a;
	} entry_t;

endpackage

// ===== sv/lockstep_triple_mismatch_detector.sv =====
// Lockstep triple mismatch detector: history ring, compare and desync bookkeeping.
// Path: an accepted input beat is registered in stage 1, then in the result register.
// Throughput: one beat per cycle unless the master stalls; the ring is read once per beat
//   at the accept edge; compare and counter update fit the single stage before the result register.
// Reset: arst_n clears the valid bits, counter, desync flag, first bad tick and handshake
//   state at once, and loads the threshold with 8; no clearing pass is needed.
module lockstep_triple_mismatch_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata from bit 0: tick[63:0], word_a[31:0], word_b[31:0], word_c[31:0],
	// link_up, msg_complete, zero padding
	input  logic [ltmd_pkg::S_TDATA_W-1:0]       s_tdata,
	// tuser: cmd[1:0]
	input  logic [ltmd_pkg::CMD_W-1:0]           s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata from bit 0: send_now, desync_flag, first_bad_tick[63:0],
	// mismatch_level[7:0], zero padding
	output logic [ltmd_pkg::M_TDATA_W-1:0]       m_tdata,
	// tuser: status[1:0]
	output logic [ltmd_pkg::STATUS_W-1:0]        m_tuser,
	// register port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ltmd_pkg::PADDR_W-1:0]         paddr,
	input  logic [ltmd_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ltmd_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import ltmd_pkg::*;

	// ---------------------------------------------------------------
	// Register port: one threshold register at byte address 0
	// ---------------------------------------------------------------
	logic [LEVEL_W-1:0]   thr_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_hit;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_hit = (reg_idx == REG_THRESHOLD) && (paddr[1:0] == 2'b00);
	assign prdata  = reg_hit ? APB_DATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			thr_q <= pwdata[LEVEL_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Input beat decode
	// ---------------------------------------------------------------
	logic                     in_acc;
	logic [CMD_W-1:0]         in_cmd;
	entry_t                   in_entry;
	logic                     in_link;
	logic                     in_cmpl;
	logic [SLOT_W-1:0]        in_slot;
	logic                     wr_en;

	assign in_acc          = s_tvalid && s_tready;
	assign in_cmd          = s_tuser;
	assign in_entry.tick   = s_tdata[TICK_W-1:0];
	assign in_entry.word_a = s_tdata[TICK_W +: WORD_W];
	assign in_entry.word_b = s_tdata[TICK_W + WORD_W +: WORD_W];
	assign in_entry.word_c = s_tdata[TICK_W + 2*WORD_W +: WORD_W];
	assign in_link         = s_tdata[TICK_W + 3*WORD_W];
	assign in_cmpl         = s_tdata[TICK_W + 3*WORD_W + 1];
	// ring depth is a power of two, so the slot is the low tick bits
	assign in_slot         = in_entry.tick[SLOT_W-1:0];
	assign wr_en           = in_acc && (in_cmd == CMD_SUBMIT) && in_link;

	// ---------------------------------------------------------------
	// History ring. Writes and reads both happen at the accept edge, so a
	// report always sees every submit accepted before it; a submit never
	// uses its own read data, so same-edge read/write needs no bypass.
	// ---------------------------------------------------------------
	entry_t                   ring_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] valid_q;
	entry_t                   rd_s1;
	logic                     vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[in_slot] <= in_entry;
		end
		if (in_acc) begin
			rd_s1 <= ring_mem[in_slot];
		end
	end

	// valid bits live in flops so reset and the clear command empty the ring at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (in_acc && (in_cmd == CMD_CLEAR)) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[in_slot] <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: the accepted beat and its lookup
	// ---------------------------------------------------------------
	logic                     s1_valid_q;
	logic                     s1_adv;
	logic [CMD_W-1:0]         cmd_s1;
	entry_t                   beat_s1;
	logic                     link_s1;
	logic                     cmpl_s1;

	// stage 1 drains whenever the result register is empty or being taken
	assign s1_adv   = s1_valid_q && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= in_cmd;
			beat_s1 <= in_entry;
			link_s1 <= in_link;
			cmpl_s1 <= in_cmpl;
			vld_s1  <= valid_q[in_slot];
		end
	end

	// ---------------------------------------------------------------
	// Compare and bookkeeping update
	// ---------------------------------------------------------------
	logic [LEVEL_W-1:0]       lvl_q;
	logic                     desync_q;
	logic [TICK_W-1:0]        bad_q;

	logic                     hit;
	logic                     same;
	logic [LEVEL_W-1:0]       lvl_inc;
	logic [LEVEL_W-1:0]       lvl_dec;
	logic [LEVEL_W-1:0]       nxt_lvl;
	logic                     nxt_desync;
	logic [TICK_W-1:0]        nxt_bad;
	status_t                  res_status;
	logic                     res_send;

	assign hit  = cmpl_s1 && !desync_q && vld_s1 && (rd_s1.tick == beat_s1.tick);
	assign same = (rd_s1.word_a == beat_s1.word_a) &&
	              (rd_s1.word_b == beat_s1.word_b) &&
	              (rd_s1.word_c == beat_s1.word_c);

	// saturate at the top, stop at zero at the bottom
	assign lvl_inc = (lvl_q == LEVEL_MAX) ? lvl_q : LEVEL_W'(lvl_q + 1'b1);
	assign lvl_dec = (lvl_q == '0) ? lvl_q : LEVEL_W'(lvl_q - 1'b1);

	always_comb begin
		nxt_lvl    = lvl_q;
		nxt_desync = desync_q;
		nxt_bad    = bad_q;
		res_status = ST_IGNORED;
		res_send   = 1'b0;
		unique case (cmd_s1)
			CMD_SUBMIT: begin
				if (link_s1) begin
					res_status = ST_STORED;
					res_send   = 1'b1;
				end
			end
			CMD_REPORT: begin
				if (hit && same) begin
					nxt_lvl    = lvl_dec;
					res_status = ST_MATCH;
				end else if (hit) begin
					nxt_lvl    = lvl_inc;
					// a zero tick reads as unset, so it never sticks
					if (bad_q == '0) begin
						nxt_bad = beat_s1.tick;
					end
					if (lvl_inc >= thr_q) begin
						nxt_desync = 1'b1;
					end
					res_status = ST_MISMATCH;
				end
			end
			CMD_CLEAR: begin
				nxt_lvl    = '0;
				nxt_desync = 1'b0;
				nxt_bad    = '0;
				res_status = ST_STORED;
			end
			default: begin
				// reserved command: drop it, state holds
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q    <= '0;
			desync_q <= 1'b0;
			bad_q    <= '0;
		end else if (s1_adv) begin
			lvl_q    <= nxt_lvl;
			desync_q <= nxt_desync;
			bad_q    <= nxt_bad;
		end
	end

	// ---------------------------------------------------------------
	// Result register: holds a finished beat until the master side takes it;
	// stage 1 waits behind it while it is held
	// ---------------------------------------------------------------
	status_t                  out_status_q;
	logic                     out_send_q;
	logic                     out_desync_q;
	logic [TICK_W-1:0]        out_bad_q;
	logic [LEVEL_W-1:0]       out_lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_status_q <= res_status;
			out_send_q   <= res_send;
			out_desync_q <= nxt_desync;
			out_bad_q    <= nxt_bad;
			out_lvl_q    <= nxt_lvl;
		end
	end

	assign m_tuser = out_status_q;
	assign m_tdata = {{M_PAD_W{1'b0}}, out_lvl_q, out_bad_q, out_desync_q, out_send_q};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// desync only drops through a clear command
	a_desync_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(desync_q && !(s1_adv && (cmd_s1 == CMD_CLEAR))) |=> desync_q)
		else $error("desync flag dropped without a clear");

	// a compare result is never a broadcast request
	a_cmp_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ((m_tuser == ST_MATCH) || (m_tuser == ST_MISMATCH))) |-> !m_tdata[0])
		else $error("send_now set on a compare result");

	// a mismatch always leaves a nonzero level behind
	a_mismatch_level: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (res_status == ST_MISMATCH)) |=> (lvl_q != '0))
		else $error("mismatch left the level at zero");

	// input back-pressure only while stage 1 is occupied and the result register is held
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && m_tvalid && !m_tready))
		else $error("input stalled with room downstream");

endmodule
